// ===== src/mbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbf_pkg
// Pixel format codes and widths for the 2x2 mipmap box filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mbf_pkg;

  localparam int unsigned PIX_W = 32;
  localparam int unsigned FMT_W = 3;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB565   = 3'd0,
    FMT_RGBA5551 = 3'd1,
    FMT_RGBA8888 = 3'd2,
    FMT_RGB888   = 3'd3,
    FMT_LA88     = 3'd4,
    FMT_A8       = 3'd5,
    FMT_L8       = 3'd6,
    FMT_RGBA4444 = 3'd7
  } pix_fmt_t;

  localparam pix_fmt_t FMT_RESET = FMT_RGB565;

  // Sum of four channel values plus bias, shifted right by two.
  // pos/width are constants at every call site.
  function automatic logic [7:0] avg_field(
    input logic [PIX_W-1:0] a,
    input logic [PIX_W-1:0] b,
    input logic [PIX_W-1:0] c,
    input logic [PIX_W-1:0] d,
    input int unsigned      pos,
    input int unsigned      width,
    input logic [1:0]       bias
  );
    logic [PIX_W-1:0] m;
    logic [9:0]       s;
    m = (32'd1 << width) - 32'd1;
    s = 10'(((a >> pos) & m)) + 10'(((b >> pos) & m)) +
        10'(((c >> pos) & m)) + 10'(((d >> pos) & m)) + 10'(bias);
    return 8'((s >> 2) & 10'(m));
  endfunction

endpackage

`default_nettype wire

// ===== src/mipmap_box_filter_2x2.sv =====
// ----------------------------------------------------------------------------
// mipmap_box_filter_2x2
// 2x2 box filter: averages the four pixels of a quad into one mipmap pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one 2x2 quad per beat: the four
//   source pixels in the low bits of 32-bit words. Output channel
//   (out_valid/out_ready) carries one averaged pixel per beat, bits above the
//   format's pixel width are zero.
//   cfg_wr_en/cfg_wr_data write the 3-bit pixel format; write it only while
//   no beat is in flight.
//   Path: an input beat is captured in the input register, then its result
//   in the result register, which drives out_valid.
//   Throughput: one quad per cycle while out_ready stays high; set by the single
//   add-and-shift pass per channel between the two register stages.
//   Reset (rst_n low, synchronous): both stages empty, format back to RGB565.
//   Stall: when out_ready is low the result register holds; the input stage
//   takes one more beat if it is empty, then in_ready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module mipmap_box_filter_2x2
  import mbf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [FMT_W-1:0]  cfg_wr_data,
  // quad input
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PIX_W-1:0]  in_top_left,
  input  wire logic [PIX_W-1:0]  in_top_right,
  input  wire logic [PIX_W-1:0]  in_bottom_left,
  input  wire logic [PIX_W-1:0]  in_bottom_right,
  // averaged pixel output
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIX_W-1:0]       out_averaged_pixel
);

  pix_fmt_t         fmt_r;

  // input stage
  logic             s1_valid_r;
  logic [PIX_W-1:0] tl_r, tr_r, bl_r, br_r;
  logic             s1_adv;

  // result stage
  logic             out_valid_r;
  logic [PIX_W-1:0] res_r;
  logic [PIX_W-1:0] res_nxt;
  logic             s2_ready;

  // Format register; the user must write it only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RESET;
    end else if (cfg_wr_en) begin
      fmt_r <= pix_fmt_t'(cfg_wr_data);
    end
  end

  // Handshake: result stage frees when empty or taken, input stage when
  // empty or when it moves on.
  assign s2_ready = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Quad payload; no reset needed.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tl_r <= in_top_left;
      tr_r <= in_top_right;
      bl_r <= in_bottom_left;
      br_r <= in_bottom_right;
    end
  end

  // Per-channel averages, all formats computed in parallel.
  logic [7:0] byte_avg [4];
  logic [3:0] nib_avg  [4];
  logic [4:0] r565, b565;
  logic [5:0] g565;
  logic [4:0] r5551, g5551, b5551;
  logic       a5551;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      byte_avg[k] = avg_field(tl_r, tr_r, bl_r, br_r, 8 * k, 8, 2'd0);
      nib_avg[k]  = 4'(avg_field(tl_r, tr_r, bl_r, br_r, 4 * k, 4, 2'd0));
    end
    r565  = 5'(avg_field(tl_r, tr_r, bl_r, br_r, 11, 5, 2'd0));
    g565  = 6'(avg_field(tl_r, tr_r, bl_r, br_r, 5, 6, 2'd0));
    b565  = 5'(avg_field(tl_r, tr_r, bl_r, br_r, 0, 5, 2'd0));
    // RGBA5551 rounds: +2 before the shift.
    r5551 = 5'(avg_field(tl_r, tr_r, bl_r, br_r, 11, 5, 2'd2));
    g5551 = 5'(avg_field(tl_r, tr_r, bl_r, br_r, 6, 5, 2'd2));
    b5551 = 5'(avg_field(tl_r, tr_r, bl_r, br_r, 1, 5, 2'd2));
    a5551 = 1'(avg_field(tl_r, tr_r, bl_r, br_r, 0, 1, 2'd2));
  end

  // Pack per format, zero above the pixel width.
  always_comb begin
    case (fmt_r)
      FMT_RGB565: begin
        res_nxt = {16'd0, r565, g565, b565};
      end
      FMT_RGBA5551: begin
        res_nxt = {16'd0, r5551, g5551, b5551, a5551};
      end
      FMT_RGBA8888: begin
        res_nxt = {byte_avg[3], byte_avg[2], byte_avg[1], byte_avg[0]};
      end
      FMT_RGB888: begin
        res_nxt = {8'd0, byte_avg[2], byte_avg[1], byte_avg[0]};
      end
      FMT_LA88: begin
        res_nxt = {16'd0, byte_avg[1], byte_avg[0]};
      end
      FMT_A8, FMT_L8: begin
        res_nxt = {24'd0, byte_avg[0]};
      end
      FMT_RGBA4444: begin
        res_nxt = {16'd0, nib_avg[3], nib_avg[2], nib_avg[1], nib_avg[0]};
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_averaged_pixel = res_r;

endmodule

`default_nettype wire
